/* hw/rtl/swm_pkg.sv */
// Shared types and constants for the sliding-window median filter.
// No dependencies; the cell, the top level and the bench import this package.
`timescale 1ns / 1ps

package swm_pkg;

    // width of the window_size configuration register
    localparam int CFG_WIDTH = 7;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic step;       // a sample transfer happens this cycle
        logic flush;      // first_of_sequence with the transfer: window empty before it
        logic cfg_clear;  // window_size written: drop all entries
        logic full;       // window holds window_size entries before this sample
    } cell_ctrl_t;

endpackage

/* hw/rtl/swm_stream_if.sv */
// Stream interfaces of the sliding-window median filter: sample input, median output.
// Valid/ready handshake; depends on nothing else.
`timescale 1ns / 1ps

interface swm_in_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           first_of_sequence;

    modport source (output valid, output sample, output first_of_sequence, input ready);
    modport sink   (input valid, input sample, input first_of_sequence, output ready);
endinterface

interface swm_out_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

/* hw/rtl/swm_cell.sv */
// One cell of the sorted chain: holds one sample, its age and a valid flag.
// Depends on swm_pkg for the broadcast control struct.
`timescale 1ns / 1ps

module swm_cell #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int AGE_WIDTH    = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swm_pkg::cell_ctrl_t            ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic [AGE_WIDTH-1:0]           age_oldest,
    // from the cell below (lower rank)
    input  logic                           lo_rm,
    input  logic signed [SAMPLE_WIDTH-1:0] lo_sh_val,
    input  logic [AGE_WIDTH-1:0]           lo_sh_age,
    input  logic                           lo_sh_valid,
    input  logic                           lo_sh_gt,
    // from the cell above (higher rank)
    input  logic signed [SAMPLE_WIDTH-1:0] up_val,
    input  logic [AGE_WIDTH-1:0]           up_age,
    input  logic                           up_valid,
    input  logic                           up_gt,
    // to the neighbours
    output logic                           rm,
    output logic signed [SAMPLE_WIDTH-1:0] sh_val,
    output logic [AGE_WIDTH-1:0]           sh_age,
    output logic                           sh_valid,
    output logic                           sh_gt,
    output logic signed [SAMPLE_WIDTH-1:0] val,
    output logic [AGE_WIDTH-1:0]           age,
    output logic                           valid,
    output logic                           gt
);
    import swm_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] val_reg, val_next;
    logic [AGE_WIDTH-1:0]           age_reg, age_next;
    logic                           valid_reg, valid_next;
    logic                           live;
    logic                           evict;

    // entries are void before the new sample when a stream restarts
    assign live  = valid_reg & ~ctrl.flush;
    // empty slots count as "greater", so the sample lands at the end of the row
    assign gt    = ~live | (sample < val_reg);
    assign evict = ctrl.full & live & (age_reg == age_oldest);
    // ripples upward: at or above the evicted entry the row closes the gap
    assign rm    = lo_rm | evict;

    // contents after eviction, before insertion
    assign sh_val   = rm ? up_val   : val_reg;
    assign sh_age   = rm ? up_age   : age_reg;
    assign sh_valid = rm ? up_valid : live;
    assign sh_gt    = rm ? up_gt    : gt;

    assign val   = val_reg;
    assign age   = age_reg;
    assign valid = live;

    always_comb
    begin
        if (lo_sh_gt)
        begin
            val_next = lo_sh_val;
            age_next = lo_sh_age + 1'b1;
        end
        else if (sh_gt)
        begin
            val_next = sample;
            age_next = '0;
        end
        else
        begin
            val_next = sh_val;
            age_next = sh_age + 1'b1;
        end
        valid_next = lo_sh_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.cfg_clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

/* hw/rtl/sliding_window_median.sv */
// Sliding-window running median: top level with the cell chain and the output register.
// Depends on swm_pkg, swm_stream_if (swm_in_if, swm_out_if) and swm_cell.
//
//  channel   | dir | fields                     | handshake
//  ----------+-----+----------------------------+----------------------------
//  samples   | in  | sample, first_of_sequence  | valid/ready transfer
//  medians   | out | median                     | valid/ready transfer
//  cfg       | in  | window_size                | cfg_we, no wait
//
// One sample a cycle while samples.ready is high: the whole row of cells evicts, shifts and
// inserts in the transfer cycle. The median is then picked from the row into the output
// register once that register is free or read, so a result passes the cell row and then the
// output register. Reset empties the window and sets window_size to 3 (WINDOW_MAX if smaller).
// A stalled median blocks a new sample only when a second median is already waiting in the row.
`timescale 1ns / 1ps

module sliding_window_median #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    swm_in_if.sink                      samples,
    swm_out_if.source                   medians,
    input  logic                        cfg_we,
    input  logic [swm_pkg::CFG_WIDTH-1:0] cfg_wdata
);
    import swm_pkg::*;

    localparam int AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int KW      = $clog2(WINDOW_MAX + 1);
    localparam int K_RESET = (WINDOW_MAX < 3) ? WINDOW_MAX : 3;

    logic [KW-1:0] k_reg, k_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic [AW-1:0] oldest_reg, oldest_next;
    logic [KW-1:0] count_reg, count_next;
    logic          pend_reg;
    logic          out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] median_reg;

    logic          accept;
    logic          load;
    logic          emits;
    logic [KW-1:0] count_base;
    cell_ctrl_t    ctrl;
    logic signed [SAMPLE_WIDTH-1:0] pick;

    logic                           rm_w       [WINDOW_MAX+1];
    logic signed [SAMPLE_WIDTH-1:0] sh_val_w   [WINDOW_MAX+1];
    logic [AW-1:0]                  sh_age_w   [WINDOW_MAX+1];
    logic                           sh_valid_w [WINDOW_MAX+1];
    logic                           sh_gt_w    [WINDOW_MAX+1];
    logic signed [SAMPLE_WIDTH-1:0] val_w      [WINDOW_MAX+1];
    logic [AW-1:0]                  age_w      [WINDOW_MAX+1];
    logic                           valid_w    [WINDOW_MAX+1];
    logic                           gt_w       [WINDOW_MAX+1];

    assign samples.ready = ~pend_reg | ~out_valid_reg | medians.ready;
    assign accept        = samples.valid & samples.ready;
    assign load          = pend_reg & (~out_valid_reg | medians.ready);

    // window length clamped to 1..WINDOW_MAX, with the median rank and oldest age
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            k_next = KW'(1);
        end
        else if (int'(cfg_wdata) > WINDOW_MAX)
        begin
            k_next = KW'(WINDOW_MAX);
        end
        else
        begin
            k_next = KW'(cfg_wdata);
        end
        oldest_next = AW'(k_next - 1'b1);
        mid_next    = AW'((k_next - 1'b1) >> 1);
    end

    assign count_base = samples.first_of_sequence ? '0 : count_reg;
    assign ctrl.step      = accept;
    assign ctrl.flush     = samples.first_of_sequence;
    assign ctrl.cfg_clear = cfg_we;
    assign ctrl.full      = (count_base == k_reg);
    assign count_next     = ctrl.full ? k_reg : count_base + 1'b1;
    assign emits          = (count_next == k_reg);

    // bottom boundary: nothing below rank 0, it always takes a value
    assign rm_w[0]       = 1'b0;
    assign sh_val_w[0]   = '0;
    assign sh_age_w[0]   = '0;
    assign sh_valid_w[0] = 1'b1;
    assign sh_gt_w[0]    = 1'b0;
    // top boundary: an empty slot above the last cell
    assign val_w[WINDOW_MAX]   = '0;
    assign age_w[WINDOW_MAX]   = '0;
    assign valid_w[WINDOW_MAX] = 1'b0;
    assign gt_w[WINDOW_MAX]    = 1'b1;

    // index i of the wires: lower-neighbour outputs of cell i-1 go in slot i,
    // own state of cell i goes in slot i (read by cell i-1 as "up")
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_WIDTH    (AW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .sample      (samples.sample),
            .age_oldest  (oldest_reg),
            .lo_rm       (rm_w[i]),
            .lo_sh_val   (sh_val_w[i]),
            .lo_sh_age   (sh_age_w[i]),
            .lo_sh_valid (sh_valid_w[i]),
            .lo_sh_gt    (sh_gt_w[i]),
            .up_val      (val_w[i+1]),
            .up_age      (age_w[i+1]),
            .up_valid    (valid_w[i+1]),
            .up_gt       (gt_w[i+1]),
            .rm          (rm_w[i+1]),
            .sh_val      (sh_val_w[i+1]),
            .sh_age      (sh_age_w[i+1]),
            .sh_valid    (sh_valid_w[i+1]),
            .sh_gt       (sh_gt_w[i+1]),
            .val         (val_w[i]),
            .age         (age_w[i]),
            .valid       (valid_w[i]),
            .gt          (gt_w[i])
        );
    end

    // median tap: one cell matches the rank
    always_comb
    begin
        pick = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            if (mid_reg == AW'(i))
            begin
                pick = pick | val_w[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= KW'(K_RESET);
            oldest_reg    <= AW'(K_RESET - 1);
            mid_reg       <= AW'((K_RESET - 1) / 2);
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                k_reg      <= k_next;
                oldest_reg <= oldest_next;
                mid_reg    <= mid_next;
                count_reg  <= '0;
            end
            else if (accept)
            begin
                count_reg <= count_next;
            end

            if (accept && emits)
            begin
                pend_reg <= 1'b1;
            end
            else if (load)
            begin
                pend_reg <= 1'b0;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (medians.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            median_reg <= pick;
        end
    end

    assign medians.valid  = out_valid_reg;
    assign medians.median = median_reg;

endmodule

/* tb/tb_sliding_window_median.sv */
// Self-checking bench for the sliding-window median filter: directed and random sample
// streams over several window sizes, checked against a behavioural window model.
// Depends on swm_pkg, swm_stream_if and the sliding_window_median RTL.
`timescale 1ns / 1ps

module tb_sliding_window_median;
    import swm_pkg::*;

    localparam int WIN_MAX       = 64;
    localparam int SW            = 32;
    localparam int SETTLE_CYCLES = 4;
    localparam int NUM_PHASES    = 11;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 first;
    } sample_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_WIDTH-1:0] cfg_wdata;

    swm_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
    swm_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

    sliding_window_median #(
        .WINDOW_MAX   (WIN_MAX),
        .SAMPLE_WIDTH (SW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (in_ch.sink),
        .medians   (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    sample_item_t         pending_samples[$];
    logic signed [SW-1:0] expected_medians[$];

    // window model: ascending values, each with its age (0 = newest)
    logic signed [SW-1:0] win_val [WIN_MAX];
    int                   win_age [WIN_MAX];
    int                   win_fill;
    logic [CFG_WIDTH-1:0] win_size_reg;

    bit no_stalls;
    int in_gap;
    int out_stall;
    int fail_count;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        if (no_stalls)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6, 7: return $urandom_range(0, 16) - 8;   // dense values, many ties
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default:
            begin
                if ($urandom_range(0, 1))
                    return 32'h8000_0000 + $urandom_range(0, 15);
                return 32'h7FFF_FFFF - $urandom_range(0, 15);
            end
        endcase
    endfunction

    // Evict the oldest once full, age the rest, insert in order after equal values.
    function automatic void median_step(input logic signed [SW-1:0] s, input logic first,
                                        output bit produced, output logic signed [SW-1:0] med);
        int  k;
        int  pos;
        bit  found;
        k = (win_size_reg == 0) ? 1 : ((win_size_reg > WIN_MAX) ? WIN_MAX : int'(win_size_reg));
        produced = 1'b0;
        med      = '0;
        if (first)
            win_fill = 0;
        if (win_fill > k)
            win_fill = 0;
        if (win_fill == k)
        begin
            pos   = win_fill - 1;
            found = 1'b0;
            for (int i = 0; i < win_fill; i++)
            begin
                if (!found && win_age[i] == k - 1)
                begin
                    pos   = i;
                    found = 1'b1;
                end
            end
            for (int i = pos; i + 1 < win_fill; i++)
            begin
                win_val[i] = win_val[i + 1];
                win_age[i] = win_age[i + 1];
            end
            win_fill--;
        end
        for (int i = 0; i < win_fill; i++)
            win_age[i]++;
        pos = win_fill;
        while (pos > 0 && s < win_val[pos - 1])
        begin
            win_val[pos] = win_val[pos - 1];
            win_age[pos] = win_age[pos - 1];
            pos--;
        end
        win_val[pos] = s;
        win_age[pos] = 0;
        win_fill++;
        if (win_fill == k)
        begin
            produced = 1'b1;
            med      = win_val[(k - 1) / 2];
        end
    endfunction

    task automatic push_item(input logic signed [SW-1:0] s, input logic first);
        sample_item_t it;
        it.sample = s;
        it.first  = first;
        pending_samples.push_back(it);
    endtask

    // all queued samples sent, nothing outstanding, then let the row drain
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_ch.valid || expected_medians.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_WIDTH-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        win_size_reg = v;
        win_fill     = 0;
    endtask

    // sample driver
    always @(posedge clk)
    begin : drv
        sample_item_t it;
        if (rst_n && (!in_ch.valid || in_ch.ready))
        begin
            if (in_gap > 0)
            begin
                in_gap      <= in_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                it = pending_samples.pop_front();
                in_ch.valid             <= 1'b1;
                in_ch.sample            <= it.sample;
                in_ch.first_of_sequence <= it.first;
                in_gap                  <= pick_gap();
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: predict on sample transfers, check median transfers, stall the sink
    always @(posedge clk)
    begin : mon
        logic signed [SW-1:0] want;
        bit                   produced;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_medians.size() == 0)
                begin
                    $error("median: no transfer expected, got %0d", out_ch.median);
                    fail_count++;
                end
                else
                begin
                    want = expected_medians.pop_front();
                    if (out_ch.median !== want)
                    begin
                        $error("median: expected %0d, got %0d", want, out_ch.median);
                        fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                median_step(in_ch.sample, in_ch.first_of_sequence, produced, want);
                if (produced)
                    expected_medians.push_back(want);
            end
            if (out_stall > 0)
            begin
                out_ch.ready <= 1'b0;
                out_stall    <= out_stall - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                out_stall    <= pick_gap();
            end
        end
    end

    initial
    begin
        int sizes [NUM_PHASES];
        int lens  [NUM_PHASES];
        int first_pct;
        sizes = '{1, 0, 2, 64, 5, 127, 4, 8, 0, 3, 3};
        lens  = '{40, 30, 50, 100, 50, 90, 50, 40, 45, 30, 25};
        sizes[8] = $urandom_range(6, 40);

        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = '0;
        in_ch.valid             = 1'b0;
        in_ch.sample            = '0;
        in_ch.first_of_sequence = 1'b0;
        out_ch.ready            = 1'b0;
        win_size_reg            = CFG_WIDTH'(3);
        win_fill                = 0;
        fail_count              = 0;
        no_stalls               = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed, window of 3 from reset
        push_item(32'h7FFF_FFFF, 1'b1);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(-1, 1'b0);
        push_item(1, 1'b0);
        push_item(5, 1'b0);
        push_item(5, 1'b0);
        push_item(5, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        push_item(100, 1'b1);
        push_item(-100, 1'b0);
        push_item(7, 1'b1);          // restart before the window fills
        push_item(8, 1'b0);
        push_item(9, 1'b0);
        push_item(32'h7FFF_FFFF, 1'b0);
        push_item(32'h7FFF_FFFE, 1'b0);
        push_item(-2, 1'b0);
        push_item(32'h5555_5555, 1'b0);
        push_item(32'hAAAA_AAAA, 1'b0);

        // last two phases rewrite the same size: the window must still be emptied
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_window(CFG_WIDTH'(sizes[p]));
            no_stalls = (p % 4 == 3);
            first_pct = (sizes[p] >= 32) ? 1 : 4;
            for (int i = 0; i < lens[p]; i++)
                push_item(rand_sample(), $urandom_range(0, 99) < first_pct);
        end

        wait_idle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
